FILE: hdl/edge_junction_noise_pruner_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the edge junction noise pruner
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EDGE_JUNCTION_NOISE_PRUNER_MACROS_SVH
`define EDGE_JUNCTION_NOISE_PRUNER_MACROS_SVH

// Same-cycle implication.
`define EJNP_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define EJNP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/ejnp_pkg.sv
// ----------------------------------------------------------------------------
// ejnp_pkg
// Types and constants of the edge junction noise pruner.
// ----------------------------------------------------------------------------
`default_nettype none

package ejnp_pkg;

	localparam int DIM_W     = 12;
	localparam int DIM_MAX   = (1 << DIM_W) - 1;
	localparam int PIX_W     = 8;
	localparam int NB_W      = 4;
	localparam int CFG_IDX_W = 2;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_IMAGE_HEIGHT  = 2'd1,
		REG_MAX_NEIGHBORS = 2'd2,
		REG_NONE          = 2'd3
	} reg_idx_t;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
	localparam logic [NB_W-1:0]  MAXNB_RESET  = 4'd2;
	localparam logic [DIM_W-1:0] DIM_MIN      = 12'd3;

	// Per-beat control carried from the input stage to the decision stage.
	typedef struct packed {
		op_t  kind;
		logic emit;
		logic bound;
		logic last;
	} stage_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/edge_junction_noise_pruner.sv
// ----------------------------------------------------------------------------
// edge_junction_noise_pruner
// Streaming 3x3 neighbor-count pruning of a raster-order 8-bit edge image.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle on the input channel, unless a
// held output beat that out_ready has not taken stalls it, and gives at
// most one beat per input beat on the output channel. Each beat passes an
// input stage (line store reads are registered there) and one decision step
// into the output register, which holds the result until it is taken. In
// pixel terms the output lags the input by image_width+1 pixels; after the
// last pixel of a frame, image_width+1 flush beats (op = 1) push out the
// tail, the last of them carrying frame_end.
// Border pixels come out as 0, nonzero pixels with more than max_neighbors
// nonzero 8-neighbors are cleared, all others pass unchanged. The two line
// stores are plain memories with no clearing pass after reset. Writing
// image_width or image_height restarts the frame; write configuration only
// while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "edge_junction_noise_pruner_macros.svh"

module edge_junction_noise_pruner #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Configuration write port.
	input  wire logic                           cfg_write,
	input  wire logic [ejnp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ejnp_pkg::DIM_W-1:0]     cfg_data,
	// Input channel.
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire ejnp_pkg::op_t                  op,
	input  wire logic [ejnp_pkg::PIX_W-1:0]     pixel_in,
	// Output channel.
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [ejnp_pkg::PIX_W-1:0]          pixel_out,
	output logic                                frame_end
);

	import ejnp_pkg::*;

	// The width register is 12 bits wide, so the usable maximum is the
	// smaller of the parameter and the register range.
	localparam int MAXW_EFF = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
	localparam int MAXH_EFF = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
	localparam int AW       = $clog2(MAX_WIDTH);
	localparam int RW       = $clog2(MAXH_EFF + 1);
	localparam int CMPW     = ((AW > DIM_W) ? AW : DIM_W) + 1;
	localparam int RCW      = ((RW > DIM_W) ? RW : DIM_W) + 1;

	// ---------------------------------------------------------------- config
	logic [DIM_W-1:0] image_width_q;
	logic [DIM_W-1:0] image_height_q;
	logic [NB_W-1:0]  max_nb_q;
	logic             restart_cfg;

	assign restart_cfg = cfg_write &&
		(cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
			max_nb_q       <= MAXNB_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:   image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT:  image_height_q <= cfg_data;
				REG_MAX_NEIGHBORS: max_nb_q       <= cfg_data[NB_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamped frame dimensions in use.
	logic [DIM_W-1:0] w_used;
	logic [DIM_W-1:0] h_used;
	logic [DIM_W-1:0] w_m1;
	logic [DIM_W-1:0] h_m1;

	always_comb begin
		priority if (image_width_q < DIM_MIN) begin
			w_used = DIM_MIN;
		end else if (image_width_q > DIM_W'(MAXW_EFF)) begin
			w_used = DIM_W'(MAXW_EFF);
		end else begin
			w_used = image_width_q;
		end
		priority if (image_height_q < DIM_MIN) begin
			h_used = DIM_MIN;
		end else if (image_height_q > DIM_W'(MAXH_EFF)) begin
			h_used = DIM_W'(MAXH_EFF);
		end else begin
			h_used = image_height_q;
		end
		w_m1 = w_used - DIM_W'(1);
		h_m1 = h_used - DIM_W'(1);
	end

	// ------------------------------------------------------- input counters
	// in_row_q reaches h_used once every pixel of the frame has been taken;
	// from then on only flush beats do anything. out_row_q/out_col_q give the
	// raster position of the next result and advance when an emitting beat is taken.
	logic [AW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [AW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;

	logic in_col_first, in_col_last, in_row_first, in_row_last, in_row_done;
	logic out_col_first, out_col_last, out_row_first, out_row_last;
	logic pix_emit;

	always_comb begin
		in_col_first  = (in_col_q == '0);
		in_col_last   = (CMPW'(in_col_q) == CMPW'(w_m1));
		in_row_first  = (in_row_q == '0);
		in_row_last   = (RCW'(in_row_q) == RCW'(h_m1));
		in_row_done   = (RCW'(in_row_q) >= RCW'(h_used));
		out_col_first = (out_col_q == '0);
		out_col_last  = (CMPW'(out_col_q) == CMPW'(w_m1));
		out_row_first = (out_row_q == '0);
		out_row_last  = (RCW'(out_row_q) == RCW'(h_m1));
		// The window is centered on a real pixel once one row and one pixel
		// have gone in.
		pix_emit = (RCW'(in_row_q) >= RCW'(2)) ||
			((RCW'(in_row_q) == RCW'(1)) && !in_col_first);
	end

	logic accept, take_pixel, take_flush, emit_now, last_now;
	logic [PIX_W-1:0] pix_forced;

	assign accept     = in_valid && in_ready;
	assign take_pixel = accept && (op == OP_PIXEL) && !in_row_done;
	// A flush only counts while the tail of a frame is still owed.
	assign take_flush = accept && (op == OP_FLUSH) && in_row_done;
	assign emit_now   = take_flush || (take_pixel && pix_emit);
	assign last_now   = emit_now && out_row_last && out_col_last;
	// Border pixels are cleared on the way in, so they also count as zero
	// neighbors.
	assign pix_forced = (in_row_first || in_row_last || in_col_first || in_col_last) ?
		'0 : pixel_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart_cfg || last_now) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (take_pixel) begin
				if (in_col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= in_col_q + AW'(1);
				end
			end
			if (emit_now) begin
				if (out_col_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + RW'(1);
				end else begin
					out_col_q <= out_col_q + AW'(1);
				end
			end
		end
	end

	// ----------------------------------------------------------- input stage
	logic             valid_s1;
	stage_ctl_t       ctl_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [AW-1:0]    addr_s1;
	logic [PIX_W-1:0] up_rd_s1;
	logic [PIX_W-1:0] mid_rd_s1;
	logic             adv_s1;

	assign adv_s1   = valid_s1 && (!ctl_s1.emit || !out_valid || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= take_pixel || take_flush;
		end
	end

	always_ff @(posedge clk) begin
		if (take_pixel || take_flush) begin
			ctl_s1.kind  <= op;
			ctl_s1.emit  <= emit_now;
			ctl_s1.bound <= out_row_first || out_row_last || out_col_first || out_col_last;
			ctl_s1.last  <= last_now;
			pix_s1       <= pix_forced;
			addr_s1      <= in_col_q;
		end
	end

	// ----------------------------------------------------------- line stores
	// The middle store is read and rewritten at the column of the beat being
	// taken. The upper store is written with the old middle value while the
	// beat sits in the input stage; that column is not read again
	// until at least three beats later.
	logic [PIX_W-1:0] mem_up  [MAX_WIDTH];
	logic [PIX_W-1:0] mem_mid [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (take_pixel) begin
			up_rd_s1 <= mem_up[in_col_q];
		end
		if (valid_s1 && ctl_s1.kind == OP_PIXEL) begin
			mem_up[addr_s1] <= mid_rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_pixel) begin
			mid_rd_s1         <= mem_mid[in_col_q];
			mem_mid[in_col_q] <= pix_forced;
		end
	end

	// ---------------------------------------------------------------- window
	// win_q[row][col]: row 0 is the oldest line, column 2 the newest pixel.
	logic [PIX_W-1:0] win_q [3][3];
	logic [PIX_W-1:0] new_col [3];

	assign new_col[0] = up_rd_s1;
	assign new_col[1] = mid_rd_s1;
	assign new_col[2] = pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (restart_cfg || (adv_s1 && ctl_s1.last)) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (adv_s1 && ctl_s1.kind == OP_PIXEL) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
				win_q[i][2] <= new_col[i];
			end
		end
	end

	// -------------------------------------------------------------- decision
	// The decision looks at the window as it stands after this beat's shift:
	// the center is the middle row's current newest entry, and the neighbors are
	// the remaining old entries plus the incoming column.
	logic [PIX_W-1:0] centre;
	logic [7:0]       nz;
	logic [NB_W-1:0]  nb_count;
	logic [PIX_W-1:0] result;

	always_comb begin
		centre   = win_q[1][2];
		nz[0]    = (win_q[0][1] != '0);
		nz[1]    = (win_q[0][2] != '0);
		nz[2]    = (new_col[0] != '0);
		nz[3]    = (win_q[1][1] != '0);
		nz[4]    = (new_col[1] != '0);
		nz[5]    = (win_q[2][1] != '0);
		nz[6]    = (win_q[2][2] != '0);
		nz[7]    = (new_col[2] != '0);
		nb_count = '0;
		for (int k = 0; k < 8; k++) begin
			nb_count = nb_count + NB_W'(nz[k]);
		end
		if (ctl_s1.kind == OP_FLUSH || ctl_s1.bound || centre == '0 ||
				nb_count > max_nb_q) begin
			result = '0;
		end else begin
			result = centre;
		end
	end

	// --------------------------------------------------------- output register
	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_out_q;
	logic             frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && ctl_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && ctl_s1.emit) begin
			pixel_out_q <= result;
			frame_end_q <= ctl_s1.last;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign frame_end = frame_end_q;

	// ------------------------------------------------------------ assertions
	// The last pixel of a frame sits in the bottom-right corner, a border
	// pixel, so it always comes out as zero.
	`EJNP_ASSERT(a_frame_end_zero, out_valid && frame_end, pixel_out == '0, "frame end beat carries a nonzero pixel")
	// The result column stays inside the frame.
	`EJNP_ASSERT(a_out_col_range, 1'b1, CMPW'(out_col_q) < CMPW'(w_used), "output column beyond frame width")
	// The input row count never passes the frame height.
	`EJNP_ASSERT(a_in_row_range, 1'b1, RCW'(in_row_q) <= RCW'(h_used), "input row beyond frame height")
	// After the last beat of a frame leaves the input stage the window is clear.
	`EJNP_ASSERT_NEXT(a_window_clear, adv_s1 && ctl_s1.last && !restart_cfg, win_q[1][2] == '0 && win_q[1][1] == '0, "window not cleared at frame end")

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the edge junction noise pruner
// Streams edge images of many sizes and neighbor limits through the block, with
// random idle cycles on both sides. A scoreboard predicts each filtered pixel
// from its own line stores and 3x3 window, and compares the output in order.
// ----------------------------------------------------------------------------
module tb_top;
	import ejnp_pkg::*;

	localparam int LINE_MAX       = 2048;
	localparam int RANDOM_PIXELS  = 780;
	localparam int IDLE_MAX       = 12;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int REPORT_CAP     = 100;

	// A 5x3 frame. Only the three interior pixels of the middle row survive the
	// boundary clear, so the center one sees two nonzero neighbors and the
	// outer ones see one each.
	localparam logic [7:0] DIRECTED_FRAME [0:14] = '{
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd9,   8'd128, 8'd255, 8'd7,   8'd200,
		8'd0,   8'd64,  8'd0,   8'd1,   8'd255
	};

	// Predicts the pruned pixel stream and keeps the predictions in order until
	// the matching output beats arrive.
	class pruner_scoreboard;
		typedef struct {
			logic [7:0] value;
			logic       last;
		} pixel_beat_t;

		logic [7:0]       upper_row [LINE_MAX];
		logic [7:0]       middle_row [LINE_MAX];
		logic [7:0]       win [3][3];
		int unsigned      in_col;
		int unsigned      in_row;
		int unsigned      out_index;
		logic [DIM_W-1:0] width_reg;
		logic [DIM_W-1:0] height_reg;
		logic [NB_W-1:0]  nb_limit;
		pixel_beat_t      expected_pixels [$];
		int               mismatches;

		function new();
			foreach (upper_row[i]) begin
				upper_row[i] = '0;
				middle_row[i] = '0;
			end
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			nb_limit = MAXNB_RESET;
			mismatches = 0;
			restart_frame();
		endfunction

		function void restart_frame();
			in_col = 0;
			in_row = 0;
			out_index = 0;
			foreach (win[i, j]) win[i][j] = '0;
		endfunction

		function int unsigned clamp_dim(logic [DIM_W-1:0] v);
			if (v < DIM_MIN) return DIM_MIN;
			if (v > LINE_MAX) return LINE_MAX;
			return v;
		endfunction

		function int unsigned width_used();
			return clamp_dim(width_reg);
		endfunction

		function int unsigned height_used();
			return clamp_dim(height_reg);
		endfunction

		function void apply_register(reg_idx_t idx, logic [DIM_W-1:0] data);
			case (idx)
				REG_IMAGE_WIDTH: begin
					width_reg = data;
					restart_frame();
				end
				REG_IMAGE_HEIGHT: begin
					height_reg = data;
					restart_frame();
				end
				REG_MAX_NEIGHBORS: nb_limit = data[NB_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] pruned_center(int unsigned w, int unsigned h);
			int unsigned r;
			int unsigned c;
			int unsigned count;
			r = out_index / w;
			c = out_index % w;
			count = 0;
			if (r == 0 || c == 0 || r >= h - 1 || c >= w - 1) return 8'd0;
			if (win[1][1] == 8'd0) return 8'd0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					if (!(i == 1 && j == 1) && win[i][j] != 8'd0) count++;
			if (count > nb_limit) return 8'd0;
			return win[1][1];
		endfunction

		function void push_expected(logic [7:0] v, int unsigned w, int unsigned h);
			pixel_beat_t b;
			b.value = v;
			b.last = (out_index + 1 == w * h);
			expected_pixels.push_back(b);
			out_index++;
			if (b.last) restart_frame();
		endfunction

		// Called for every accepted input beat.
		function void note_pixel_beat(op_t kind, logic [7:0] pix);
			int unsigned w;
			int unsigned h;
			int unsigned c;
			logic [7:0]  v;
			bit          primed;
			w = width_used();
			h = height_used();
			c = in_col;
			if (kind == OP_FLUSH) begin
				if (in_row >= h && out_index < w * h) push_expected(8'd0, w, h);
				return;
			end
			if (in_row >= h || c >= w) return;
			v = (in_row == 0 || in_row == h - 1 || c == 0 || c == w - 1) ? 8'd0 : pix;
			for (int i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = upper_row[c];
			win[1][2] = middle_row[c];
			win[2][2] = v;
			upper_row[c] = middle_row[c];
			middle_row[c] = v;
			primed = (in_row >= 2) || (in_row == 1 && c >= 1);
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			if (primed && out_index < w * h) push_expected(pruned_center(w, h), w, h);
		endfunction

		task flag_mismatch(string msg);
			if (mismatches < REPORT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		// Called for every accepted output beat.
		task check_pixel_beat(logic [7:0] value, logic last);
			pixel_beat_t want;
			if (expected_pixels.size() == 0) begin
				flag_mismatch($sformatf("output beat %0d/%0b with nothing predicted",
					value, last));
				return;
			end
			want = expected_pixels.pop_front();
			if (value !== want.value)
				flag_mismatch($sformatf("pixel_out %0d, predicted %0d", value, want.value));
			if (last !== want.last)
				flag_mismatch($sformatf("frame_end %0b, predicted %0b", last, want.last));
		endtask

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_write = 1'b0;
	reg_idx_t         cfg_index = REG_NONE;
	logic [DIM_W-1:0] cfg_data  = '0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	op_t              op        = OP_PIXEL;
	logic [PIX_W-1:0] pixel_in  = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [PIX_W-1:0] pixel_out;
	logic             frame_end;

	pruner_scoreboard board;
	bit               no_idle;      // both sides stream without gaps while set
	bit               in_held;      // in_valid is still high after the last beat
	bit               redo_dims;    // a cut frame left the counters mid-frame
	int               quiet_cycles;
	int               random_pixels;

	edge_junction_noise_pruner #(
		.MAX_WIDTH (LINE_MAX),
		.MAX_HEIGHT(LINE_MAX)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.pixel_in (pixel_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_out(pixel_out),
		.frame_end(frame_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_idle();
		if (no_idle) return 0;
		return $urandom_range(0, IDLE_MAX);
	endfunction

	function automatic logic [7:0] draw_pixel(int density);
		if ($urandom_range(0, 99) < density) return 8'($urandom_range(1, 255));
		return 8'd0;
	endfunction

	// Both channels are sampled here, at the rising edge, before any of the
	// nonblocking updates of that edge land. The input beat is noted before the
	// output beat is checked, and the watchdog counts edges with no beat moving.
	always @(posedge clk) begin : beat_monitor
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready === 1'b1) begin
				board.note_pixel_beat(op, pixel_in);
				moved = 1'b1;
			end
			if (out_valid === 1'b1 && out_ready) begin
				board.check_pixel_beat(pixel_out, frame_end);
				moved = 1'b1;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Output side: before each beat it holds off ready for a randomly drawn idle
	// gap, then keeps ready high until the beat is taken.
	initial begin : sink_ready
		int stall;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = draw_idle();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Presents one beat and waits for it to be taken. When the next idle gap is
	// zero, valid stays high and the next call replaces the payload in the same
	// step, so valid is never dropped and raised at one edge.
	task automatic drive_beat(op_t kind, logic [7:0] value);
		int gap;
		op <= kind;
		pixel_in <= value;
		in_valid <= 1'b1;
		in_held = 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		gap = draw_idle();
		if (gap > 0) begin
			in_valid <= 1'b0;
			in_held = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Waits until every predicted beat has come out, then lets the pipeline
	// run dry, since beats that cause no output may still be in flight.
	task automatic settle();
		if (in_held) begin
			in_valid <= 1'b0;
			in_held = 1'b0;
		end
		while (board.pending() != 0) @(negedge clk);
		@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the scoreboard takes it at the same edge as the block.
	task automatic write_register(reg_idx_t idx, logic [DIM_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.apply_register(idx, data);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Streams one frame of the current size. A noisy frame mixes in flushes
	// before the frame is complete, stray pixels after it and spare flushes
	// after its end, all of which the block must ignore. A nonnegative cut_at
	// stops the frame after that many pixels.
	task automatic stream_frame(int density, bit noisy, int cut_at);
		int unsigned w;
		int unsigned h;
		w = board.width_used();
		h = board.height_used();
		for (int n = 0; n < w * h; n++) begin
			if (n == cut_at) return;
			if (noisy && $urandom_range(0, 19) == 0) drive_beat(OP_FLUSH, 8'($urandom));
			drive_beat(OP_PIXEL, draw_pixel(density));
			random_pixels++;
		end
		if (noisy && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) drive_beat(OP_PIXEL, 8'($urandom));
		// The window trails the input by a row and a pixel; this many flushes
		// push out the rest of the frame.
		repeat (w + 1) drive_beat(OP_FLUSH, 8'($urandom));
		if (noisy && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) drive_beat(OP_FLUSH, 8'($urandom));
	endtask

	// A phase: new settings while idle, then one to three frames. Widths and
	// heights below three exercise the clamp.
	task automatic run_random_phase();
		int               frames;
		int               cut_at;
		int               density;
		logic [DIM_W-1:0] dim;
		settle();
		no_idle = ($urandom_range(0, 5) == 0);
		if (redo_dims || $urandom_range(0, 3) != 0) begin
			dim = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 2))
				: DIM_W'($urandom_range(3, 12));
			write_register(REG_IMAGE_WIDTH, dim);
			dim = ($urandom_range(0, 4) == 0) ? DIM_W'($urandom_range(0, 2))
				: DIM_W'($urandom_range(3, 9));
			write_register(REG_IMAGE_HEIGHT, dim);
			redo_dims = 1'b0;
		end
		write_register(REG_MAX_NEIGHBORS, DIM_W'($urandom));
		if ($urandom_range(0, 3) == 0) write_register(REG_NONE, DIM_W'($urandom));
		frames = $urandom_range(1, 3);
		for (int f = 0; f < frames; f++) begin
			case ($urandom_range(0, 3))
				0: density = 20;
				1: density = 50;
				2: density = 80;
				default: density = 100;
			endcase
			cut_at = -1;
			if ($urandom_range(0, 7) == 0)
				cut_at = $urandom_range(0, board.width_used() * board.height_used() - 1);
			stream_frame(density, bit'($urandom_range(0, 1)), cut_at);
			if (cut_at >= 0) begin
				redo_dims = 1'b1;
				break;
			end
		end
	endtask

	initial begin
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frame with a limit of one neighbor: the middle interior pixel
		// is cleared, its two nonzero neighbors keep their values. A write to
		// the unused index must change nothing.
		write_register(REG_NONE, 12'hFFF);
		write_register(REG_MAX_NEIGHBORS, 12'd1);
		write_register(REG_IMAGE_WIDTH, 12'd5);
		write_register(REG_IMAGE_HEIGHT, 12'd3);
		for (int k = 0; k < 15; k++) begin
			// A flush in the middle of the frame is ignored.
			if (k == 7) drive_beat(OP_FLUSH, 8'h55);
			drive_beat(OP_PIXEL, DIRECTED_FRAME[k]);
		end
		// All rows are in: this pixel is dropped.
		drive_beat(OP_PIXEL, 8'hAA);
		repeat (6) drive_beat(OP_FLUSH, 8'h00);
		// The frame has ended, so this flush finds a fresh frame and is ignored.
		drive_beat(OP_FLUSH, 8'hFF);

		// Neighbor limit at both ends: zero clears every pixel with a nonzero
		// neighbor, fifteen never clears.
		settle();
		write_register(REG_MAX_NEIGHBORS, 12'd0);
		write_register(REG_IMAGE_WIDTH, 12'd6);
		write_register(REG_IMAGE_HEIGHT, 12'd5);
		stream_frame(70, 1'b0, -1);
		settle();
		write_register(REG_MAX_NEIGHBORS, 12'hFFF);
		stream_frame(90, 1'b0, -1);

		random_pixels = 0;
		redo_dims = 1'b1;
		while (random_pixels < RANDOM_PIXELS) run_random_phase();

		settle();
		if (board.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
